>>> src/lld_pkg.sv
// ----------------------------------------------------------------------------
// lld_pkg: shared definitions for the least-loaded job dispatcher
// Widths, reset values, controller/datapath command and status types and
// the active-count clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package lld_pkg;

  // number of servers held in the completion register file
  localparam int MAX_SERVERS = 16;

  // field and index widths
  localparam int IDX_W = $clog2(MAX_SERVERS);
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int CFG_W = 5;
  localparam int JOB_W = 16;
  localparam int SRV_W = 4;
  localparam int TOT_W = 32;

  // reset value of the active server count
  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

  // saturation value of a completion total
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the job, take server 0 as the running minimum, scan from server 1
    logic scan;    // compare one more server against the running minimum
    logic update;  // add the job to the chosen server and fill the output
  } lld_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic single;     // only server 0 is active
    logic scan_last;  // the server under compare is the last active one
    logic out_free;   // the output register can take a new result
  } lld_sts_t;

  // active count: zero counts as one, large values clamp to the array depth
  function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] cfg);
    logic [CNT_W-1:0] n;
    if (cfg == '0) begin
      n = CNT_W'(1);
    end else if (int'(cfg) > MAX_SERVERS) begin
      n = CNT_W'(MAX_SERVERS);
    end else begin
      n = CNT_W'(cfg);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> src/lld_job_if.sv
// ----------------------------------------------------------------------------
// lld_job_if: job input channel
// Valid/ready channel carrying the service time of one job.
// ----------------------------------------------------------------------------
`default_nettype none

interface lld_job_if;
  import lld_pkg::*;

  logic             valid;
  logic             ready;
  logic [JOB_W-1:0] job_time;

  modport source (output valid, output job_time, input ready);
  modport sink   (input valid, input job_time, output ready);

endinterface

`default_nettype wire

>>> src/lld_result_if.sv
// ----------------------------------------------------------------------------
// lld_result_if: dispatch result channel
// Valid/ready channel carrying the chosen server and its updated total.
// ----------------------------------------------------------------------------
`default_nettype none

interface lld_result_if;
  import lld_pkg::*;

  logic             valid;
  logic             ready;
  logic [SRV_W-1:0] server_index;
  logic [TOT_W-1:0] new_completion;

  modport source (output valid, output server_index, output new_completion, input ready);
  modport sink   (input valid, input server_index, input new_completion, output ready);

endinterface

`default_nettype wire

>>> src/lld_ctrl.sv
// ----------------------------------------------------------------------------
// lld_ctrl: dispatcher controller
// Sequences accept, minimum scan and update of one job at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire lld_pkg::lld_sts_t sts,
  output lld_pkg::lld_cmd_t      cmd
);
  import lld_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    job_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.single ? S_UPDATE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // wait until the previous result has left the output register
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/lld_datapath.sv
// ----------------------------------------------------------------------------
// lld_datapath: dispatcher datapath
// Completion register file, running minimum, saturating add and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [lld_pkg::CFG_W-1:0] cfg_data,
  input  wire logic [lld_pkg::JOB_W-1:0] job_time,
  input  wire lld_pkg::lld_cmd_t         cmd,
  output lld_pkg::lld_sts_t              sts,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic [lld_pkg::SRV_W-1:0]      out_index,
  output logic [lld_pkg::TOT_W-1:0]      out_total
);
  import lld_pkg::*;

  logic [CFG_W-1:0] active_servers;
  logic [TOT_W-1:0] completion [MAX_SERVERS];
  logic [JOB_W-1:0] job;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] best_idx;
  logic [TOT_W-1:0] best_val;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] last_idx;
  logic [TOT_W:0]   sum;
  logic [TOT_W-1:0] sum_sat;
  logic [TOT_W-1:0] scan_val;

  // effective active count and last scanned index
  assign count    = eff_count(active_servers);
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign scan_val = completion[scan_idx];

  // status back to the controller
  assign sts.single    = (count == CNT_W'(1));
  assign sts.scan_last = (scan_idx == last_idx);
  assign sts.out_free  = !out_valid || out_ready;

  // saturating add of the job time to the chosen total
  assign sum     = {1'b0, best_val} + {{(TOT_W + 1 - JOB_W){1'b0}}, job};
  assign sum_sat = sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];

  // configuration, completion totals and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active_servers <= ACTIVE_RESET;
      out_valid      <= 1'b0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
        completion[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        active_servers <= cfg_data;
      end
      if (cmd.update) begin
        completion[best_idx] <= sum_sat;
        out_valid            <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // job capture and running minimum, ties keep the lower index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      job      <= job_time;
      best_idx <= '0;
      best_val <= completion[0];
      scan_idx <= IDX_W'(1);
    end else if (cmd.scan) begin
      if (scan_val < best_val) begin
        best_idx <= scan_idx;
        best_val <= scan_val;
      end
      scan_idx <= scan_idx + IDX_W'(1);
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_index <= SRV_W'(best_idx);
      out_total <= sum_sat;
    end
  end

endmodule

`default_nettype wire

>>> src/least_loaded_job_dispatcher_top.sv
// ----------------------------------------------------------------------------
// least_loaded_job_dispatcher_top: least-loaded job dispatcher
// Assigns each job to the active server with the smallest completion time
// (lowest index on ties) and returns that server and its saturated total.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake          payload
//   -------   ---   ---------          -------
//   job       in    valid / ready      job_time[15:0]
//   result    out   valid / ready      server_index[3:0], new_completion[31:0]
//   cfg       in    cfg_we             cfg_data[4:0] (active_servers)
//
// a job passes through a load step, a scan that reads one completion total
// per cycle over the active servers after server 0 (the effective active
// count is 1 to 16), and an update step for the add and write back.
// reset clears every completion total at once and sets the active count to 16.
// a waiting result sits in the output register; the next job is accepted
// meanwhile and holds in its update step until that result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module least_loaded_job_dispatcher_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [lld_pkg::CFG_W-1:0] cfg_data,
  lld_job_if.sink                        job,
  lld_result_if.source                   result
);
  import lld_pkg::*;

  lld_cmd_t cmd;
  lld_sts_t sts;

  // controller
  lld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job.valid),
    .job_ready (job.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  lld_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .job_time  (job.job_time),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_index (result.server_index),
    .out_total (result.new_completion)
  );

  // one job at a time: no accept right after an accept
  assert property (@(posedge clk) disable iff (rst)
    (job.valid && job.ready) |=> !job.ready)
    else $error("job accepted while previous job still in progress");

  // update only when the output register can take the result
  assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> sts.out_free)
    else $error("update issued while output register is full");

  // a new result appears only after an update
  assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.update))
    else $error("result valid rose without an update");

endmodule

`default_nettype wire
